// File: rtl/core/vbt_pkg.sv
// vbt_pkg: types and fixed constants of the video beam timing block
// no dependencies; used by vbt_step and video_beam_timing

package vbt_pkg;

    localparam int unsigned POS_W    = 10;
    localparam int unsigned CYCLES_W = 7;

    // beam positions in doubled units
    localparam logic [POS_W-1:0] WIDE_DOT_A        = 10'd322;
    localparam logic [POS_W-1:0] WIDE_DOT_B        = 10'd326;
    localparam logic [POS_W-1:0] ODD_LINE          = 10'd239;
    localparam logic [POS_W-1:0] VBL_LINE_OVERSCAN = 10'(32'h0F0 * 2);
    localparam logic [POS_W-1:0] VBL_LINE_NORMAL   = 10'(32'h0E1 * 2);
    localparam logic [POS_W-1:0] REFRESH_DOT       = 10'(536 / 4);
    localparam logic [POS_W-1:0] POS_STEP          = 10'd2;

    // master cycles per dot
    localparam logic [CYCLES_W-1:0] DOT_SHORT    = 7'd4;
    localparam logic [CYCLES_W-1:0] DOT_LONG     = 7'd6;
    localparam logic [CYCLES_W-1:0] HBLANK_EXTRA = 7'd68;
    localparam logic [CYCLES_W-1:0] DOT_NONE     = 7'd0;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] act_x;
        logic [POS_W-1:0] act_y;
        logic             active;
        logic             field;
    } beam_state_t;

    typedef struct packed {
        logic                vblank_begins;
        logic                hblank_begins;
        logic                vblank_ends;
        logic                hblank_ends;
        logic                refresh_point;
        logic [CYCLES_W-1:0] dot_cycles;
    } beam_events_t;

endpackage

// File: rtl/core/vbt_in_if.sv
// vbt_in_if: input channel of the beam timing block, one tick per beat
// no dependencies

interface vbt_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

// File: rtl/core/vbt_out_if.sv
// vbt_out_if: result channel of the beam timing block
// no dependencies

interface vbt_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] beam_x;
    logic [9:0] beam_y;
    logic [9:0] visible_x;
    logic [9:0] visible_y;
    logic       in_active_area;
    logic       odd_field;
    logic       vblank_begins;
    logic       hblank_begins;
    logic       vblank_ends;
    logic       hblank_ends;
    logic       refresh_point;
    logic [6:0] dot_cycles;

    modport source (
        output valid, input ready,
        output beam_x, output beam_y, output visible_x, output visible_y,
        output in_active_area, output odd_field,
        output vblank_begins, output hblank_begins, output vblank_ends,
        output hblank_ends, output refresh_point, output dot_cycles
    );
    modport sink (
        input valid, output ready,
        input beam_x, input beam_y, input visible_x, input visible_y,
        input in_active_area, input odd_field,
        input vblank_begins, input hblank_begins, input vblank_ends,
        input hblank_ends, input refresh_point, input dot_cycles
    );
endinterface

// File: rtl/core/video_beam_timing.sv
// video_beam_timing: raster beam counter with blanking events and dot cost
// depends on vbt_pkg, vbt_in_if, vbt_out_if and vbt_step
//
//   channel   dir   beat carries
//   in_ch     in    tick (advance one dot or hold)
//   out_ch    out   beam and active positions, field, blank pulses, dot_cycles
//   cfg       in    overscan_on, written with cfg_we
//
// one beat in, one beat out; a new beat is taken every cycle while the result side does not stall
// the result appears in the cycle after its input beat is taken, from the result register
// the beam state is updated in the same edge that takes the input beat
// a stalled result holds, and input is taken only when the result register
// is empty or being drained in the same cycle
// rst_n clears the beam state, the overscan setting and the result valid

module video_beam_timing #(
    parameter int unsigned LEFT_BLANK     = 44,
    parameter int unsigned VISIBLE_WIDTH  = 512,
    parameter int unsigned LINE_LENGTH    = 680,
    parameter int unsigned FRAME_LINES    = 524,
    parameter int unsigned TOP_BLANK      = 2,
    parameter int unsigned VISIBLE_HEIGHT = 478
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    vbt_in_if.sink        in_ch,
    vbt_out_if.source     out_ch
);

    // architectural beam state
    vbt_pkg::beam_state_t  state_reg;
    vbt_pkg::beam_state_t  state_next;
    vbt_pkg::beam_events_t events;
    logic                  overscan_reg;

    // result register
    logic                  res_valid_reg;
    vbt_pkg::beam_state_t  res_state_reg;
    vbt_pkg::beam_events_t res_events_reg;

    logic                  in_take;

    // input is taken whenever the result slot is free or draining now
    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    vbt_step #(
        .LEFT_BLANK     (LEFT_BLANK),
        .VISIBLE_WIDTH  (VISIBLE_WIDTH),
        .LINE_LENGTH    (LINE_LENGTH),
        .FRAME_LINES    (FRAME_LINES),
        .TOP_BLANK      (TOP_BLANK),
        .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
    ) u_step (
        .tick        (in_ch.tick),
        .overscan_on (overscan_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .ev          (events)
    );

    // control state: beam counters, setting and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            overscan_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                overscan_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_state_reg  <= state_next;
            res_events_reg <= events;
        end
    end

    assign out_ch.valid          = res_valid_reg;
    assign out_ch.beam_x         = res_state_reg.pos_x;
    assign out_ch.beam_y         = res_state_reg.pos_y;
    assign out_ch.visible_x      = res_state_reg.act_x;
    assign out_ch.visible_y      = res_state_reg.act_y;
    assign out_ch.in_active_area = res_state_reg.active;
    assign out_ch.odd_field      = res_state_reg.field;
    assign out_ch.vblank_begins  = res_events_reg.vblank_begins;
    assign out_ch.hblank_begins  = res_events_reg.hblank_begins;
    assign out_ch.vblank_ends    = res_events_reg.vblank_ends;
    assign out_ch.hblank_ends    = res_events_reg.hblank_ends;
    assign out_ch.refresh_point  = res_events_reg.refresh_point;
    assign out_ch.dot_cycles     = res_events_reg.dot_cycles;

endmodule

// File: rtl/core/vbt_step.sv
// vbt_step: next beam state and per-dot events from the current state
// depends on vbt_pkg

module vbt_step #(
    parameter int unsigned LEFT_BLANK     = 44,
    parameter int unsigned VISIBLE_WIDTH  = 512,
    parameter int unsigned LINE_LENGTH    = 680,
    parameter int unsigned FRAME_LINES    = 524,
    parameter int unsigned TOP_BLANK      = 2,
    parameter int unsigned VISIBLE_HEIGHT = 478
) (
    input  logic                 tick,
    input  logic                 overscan_on,
    input  vbt_pkg::beam_state_t cur,
    output vbt_pkg::beam_state_t nxt,
    output vbt_pkg::beam_events_t ev
);

    localparam logic [vbt_pkg::POS_W-1:0] HB_START = vbt_pkg::POS_W'(LEFT_BLANK + VISIBLE_WIDTH);
    localparam logic [vbt_pkg::POS_W-1:0] HB_END   = vbt_pkg::POS_W'(LEFT_BLANK);
    localparam logic [vbt_pkg::POS_W-1:0] LINE_END = vbt_pkg::POS_W'(LINE_LENGTH);
    localparam logic [vbt_pkg::POS_W-1:0] LAST_LINE = vbt_pkg::POS_W'(FRAME_LINES);
    localparam logic [vbt_pkg::POS_W-1:0] TOP_EDGE = vbt_pkg::POS_W'(TOP_BLANK);
    localparam logic [vbt_pkg::POS_W-1:0] BOT_EDGE =
        vbt_pkg::POS_W'(TOP_BLANK + VISIBLE_HEIGHT);

    logic [vbt_pkg::POS_W-1:0]    vline;
    logic                         wide_dot;
    logic                         vb_in;
    logic                         hb_in;
    logic                         vb_out;
    logic                         hb_out;
    logic                         line_done;
    logic [vbt_pkg::POS_W-1:0]    act_y_a;
    logic [vbt_pkg::POS_W-1:0]    act_x_a;
    logic [vbt_pkg::POS_W-1:0]    act_y_b;
    logic [vbt_pkg::CYCLES_W-1:0] base_cycles;
    vbt_pkg::beam_state_t         adv;

    always_comb
    begin
        vline       = overscan_on ? vbt_pkg::VBL_LINE_OVERSCAN : vbt_pkg::VBL_LINE_NORMAL;
        // test at the odd line never matches an even beam line
        wide_dot    = (cur.pos_x == vbt_pkg::WIDE_DOT_A || cur.pos_x == vbt_pkg::WIDE_DOT_B)
                      && cur.pos_y != vbt_pkg::ODD_LINE;
        base_cycles = wide_dot ? vbt_pkg::DOT_LONG : vbt_pkg::DOT_SHORT;
        vb_in       = (cur.pos_x == '0) && (cur.pos_y == vline);
        hb_in       = (cur.pos_x == HB_START);
        line_done   = (cur.pos_x >= LINE_END);
        vb_out      = line_done && (cur.pos_y >= LAST_LINE);
        hb_out      = (cur.pos_x == HB_END);

        // vblank exit clears the active line before hblank exit adds to it
        act_y_a = vb_out ? '0 : cur.act_y;
        act_x_a = hb_out ? '0 : cur.act_x;
        act_y_b = hb_out ? act_y_a + vbt_pkg::POS_STEP : act_y_a;

        adv.field = cur.field ^ vb_out;
        adv.act_y = act_y_b;
        if (line_done)
        begin
            adv.pos_x = '0;
            adv.pos_y = (cur.pos_y >= LAST_LINE) ? '0 : cur.pos_y + vbt_pkg::POS_STEP;
            adv.act_x = act_x_a;
        end
        else
        begin
            adv.pos_x = cur.pos_x + vbt_pkg::POS_STEP;
            adv.pos_y = cur.pos_y;
            adv.act_x = cur.active ? act_x_a + vbt_pkg::POS_STEP : act_x_a;
        end
        adv.active = (adv.pos_x >= HB_END) && (adv.pos_x < HB_START)
                     && (adv.pos_y >= TOP_EDGE) && (adv.pos_y < BOT_EDGE);

        if (tick)
        begin
            nxt              = adv;
            ev.vblank_begins = vb_in;
            ev.hblank_begins = hb_in;
            ev.vblank_ends   = vb_out;
            ev.hblank_ends   = hb_out;
            ev.refresh_point = (cur.pos_x == vbt_pkg::REFRESH_DOT);
            ev.dot_cycles    = hb_in ? base_cycles + vbt_pkg::HBLANK_EXTRA : base_cycles;
        end
        else
        begin
            nxt              = cur;
            ev.vblank_begins = 1'b0;
            ev.hblank_begins = 1'b0;
            ev.vblank_ends   = 1'b0;
            ev.hblank_ends   = 1'b0;
            ev.refresh_point = 1'b0;
            ev.dot_cycles    = vbt_pkg::DOT_NONE;
        end
    end

endmodule

// File: dv/video_beam_timing_checker.sv
// video_beam_timing_checker: watches the tick and result channels, predicts every result beat
// and compares it field by field; depends on vbt_pkg, vbt_in_if and vbt_out_if

module video_beam_timing_checker #(
    parameter int unsigned LEFT_BLANK     = 44,
    parameter int unsigned VISIBLE_WIDTH  = 512,
    parameter int unsigned LINE_LENGTH    = 680,
    parameter int unsigned FRAME_LINES    = 524,
    parameter int unsigned TOP_BLANK      = 2,
    parameter int unsigned VISIBLE_HEIGHT = 478
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    vbt_in_if           in_ch,
    vbt_out_if          out_ch,
    output int unsigned fail_count,
    output int unsigned reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        vbt_pkg::beam_state_t  st;
        vbt_pkg::beam_events_t ev;
    } beam_report_t;

    vbt_pkg::beam_state_t beam;
    logic                 overscan;
    beam_report_t         beam_reports[$];
    int unsigned          mismatches;
    int unsigned          beat_no;

    // one dot of the raster; decisions on the old position, results on the new one
    function automatic void advance_beam(input logic tick, input logic overscan_sel,
                                         inout vbt_pkg::beam_state_t st,
                                         output vbt_pkg::beam_events_t ev);
        logic [vbt_pkg::POS_W-1:0] x;
        logic [vbt_pkg::POS_W-1:0] y;
        logic [vbt_pkg::POS_W-1:0] vline;
        ev = '0;
        if (tick)
        begin
            x     = st.pos_x;
            y     = st.pos_y;
            vline = overscan_sel ? vbt_pkg::VBL_LINE_OVERSCAN : vbt_pkg::VBL_LINE_NORMAL;
            // the odd-line exception can never match an even beam line
            ev.dot_cycles    = ((x == vbt_pkg::WIDE_DOT_A || x == vbt_pkg::WIDE_DOT_B)
                                && y != vbt_pkg::ODD_LINE)
                               ? vbt_pkg::DOT_LONG : vbt_pkg::DOT_SHORT;
            ev.refresh_point = (x == vbt_pkg::REFRESH_DOT);
            ev.vblank_begins = (x == '0 && y == vline);
            ev.hblank_begins = (x == LEFT_BLANK + VISIBLE_WIDTH);
            if (ev.hblank_begins)
                ev.dot_cycles = ev.dot_cycles + vbt_pkg::HBLANK_EXTRA;
            ev.vblank_ends = (x >= LINE_LENGTH && y >= FRAME_LINES);
            if (ev.vblank_ends)
            begin
                st.field = ~st.field;
                st.act_y = '0;
            end
            ev.hblank_ends = (x == LEFT_BLANK);
            if (ev.hblank_ends)
            begin
                st.act_x = '0;
                st.act_y = st.act_y + vbt_pkg::POS_STEP;
            end
            if (x >= LINE_LENGTH)
            begin
                st.pos_y = (y >= FRAME_LINES) ? '0 : y + vbt_pkg::POS_STEP;
                st.pos_x = '0;
            end
            else
            begin
                st.pos_x = x + vbt_pkg::POS_STEP;
                if (st.active)
                    st.act_x = st.act_x + vbt_pkg::POS_STEP;
            end
            st.active = (LEFT_BLANK <= st.pos_x && st.pos_x < VISIBLE_WIDTH + LEFT_BLANK &&
                         TOP_BLANK <= st.pos_y && st.pos_y < VISIBLE_HEIGHT + TOP_BLANK);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("beat %0d: %s is %0d, predicted %0d", beat_no, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic compare_report(input beam_report_t want);
        check_field("beam_x", 32'(out_ch.beam_x), 32'(want.st.pos_x));
        check_field("beam_y", 32'(out_ch.beam_y), 32'(want.st.pos_y));
        check_field("visible_x", 32'(out_ch.visible_x), 32'(want.st.act_x));
        check_field("visible_y", 32'(out_ch.visible_y), 32'(want.st.act_y));
        check_field("in_active_area", 32'(out_ch.in_active_area), 32'(want.st.active));
        check_field("odd_field", 32'(out_ch.odd_field), 32'(want.st.field));
        check_field("vblank_begins", 32'(out_ch.vblank_begins), 32'(want.ev.vblank_begins));
        check_field("hblank_begins", 32'(out_ch.hblank_begins), 32'(want.ev.hblank_begins));
        check_field("vblank_ends", 32'(out_ch.vblank_ends), 32'(want.ev.vblank_ends));
        check_field("hblank_ends", 32'(out_ch.hblank_ends), 32'(want.ev.hblank_ends));
        check_field("refresh_point", 32'(out_ch.refresh_point), 32'(want.ev.refresh_point));
        check_field("dot_cycles", 32'(out_ch.dot_cycles), 32'(want.ev.dot_cycles));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beam_report_t          rep;
        vbt_pkg::beam_events_t ev;
        if (!rst_n)
        begin
            beam        = '0;
            overscan    = 1'b0;
            beam_reports.delete();
            mismatches  = 0;
            beat_no     = 0;
            fail_count  <= 0;
            reports_due <= 0;
        end
        else
        begin
            // the result leaving now always belongs to an older tick beat
            if (out_ch.valid && out_ch.ready)
            begin
                if (beam_reports.size() == 0)
                    report_mismatch("unpredicted result beat", 1, 0);
                else
                    compare_report(beam_reports.pop_front());
                beat_no++;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                advance_beam(in_ch.tick, overscan, beam, ev);
                rep.st = beam;
                rep.ev = ev;
                beam_reports.push_back(rep);
            end
            if (cfg_we)
                overscan = cfg_wdata;
            fail_count  <= mismatches;
            reports_due <= 32'(beam_reports.size());
        end
    end

endmodule

// File: dv/video_beam_timing_tb.sv
// video_beam_timing_tb: clock, reset, tick stimulus, result back-pressure and verdict
// depends on vbt_pkg, vbt_in_if, vbt_out_if, video_beam_timing and video_beam_timing_checker

module video_beam_timing_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // a little more than one whole line of 341 ticks
    localparam int unsigned SWEEP_BEATS = 400;
    localparam int unsigned RANDOM_BEATS = 100;
    localparam int unsigned DRAIN_PAUSE = 4;
    // slowest run: about 1000 beats with the longest gaps and stalls, taken several times over
    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    int unsigned fail_count;
    int unsigned reports_due;
    int unsigned cycle_count;
    // chance in eighths that a run of 64 beats is idled, shared by both sides
    int unsigned idle_eighths;

    vbt_in_if  in_ch();
    vbt_out_if out_ch();

    video_beam_timing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    video_beam_timing_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake must not stall the run forever
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // one tick beat: optional gap with valid low, then hold valid until taken
    // a zero gap keeps valid high so back-to-back beats need no second assignment
    task automatic send_tick(input logic t, input int unsigned gap);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.tick  <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // a stream of beats; idling comes in runs of 64 so there are quiet stretches too
    task automatic run_beats(input int unsigned count, input int unsigned eighths,
                             input int unsigned hold_sixteenths);
        logic src_idle;
        src_idle     = 1'b0;
        idle_eighths = eighths;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                src_idle = ($urandom_range(0, 7) < eighths);
            send_tick($urandom_range(0, 15) >= hold_sixteenths,
                      src_idle ? $urandom_range(0, 11) : 0);
        end
    endtask

    // let every predicted result come back, then a short pause for the result register
    task automatic drain;
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_due != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // the overscan setting is only written with the pipe empty
    task automatic write_overscan(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: per beat stall draw, redrawing the idle mode every 64 beats
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        logic        snk_idle;
        taken        = 0;
        snk_idle     = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                snk_idle = ($urandom_range(0, 7) < idle_eighths);
            stall = snk_idle ? $urandom_range(0, 11) : 0;
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        // ticks of the opening directed run, taken from bit 0 upwards
        logic [19:0] directed_ticks;
        directed_ticks = 20'b1110_1101_0111_1011_0100;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        idle_eighths = 4;
        in_ch.valid  = 1'b0;
        in_ch.tick   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 225-line display: held ticks straight after reset, then mixed gaps of 0 and 11
        write_overscan(1'b0);
        for (int unsigned i = 0; i < 20; i++)
            send_tick(directed_ticks[i], (i % 4 == 3) ? 11 : 0);

        // a whole line and a bit, so the blanking edges, the long dots,
        // the refresh dot and a line wrap all pass by
        run_beats(SWEEP_BEATS, 1, 1);
        drain();

        // 240-line display on the following lines
        write_overscan(1'b1);
        run_beats(SWEEP_BEATS, 1, 1);
        drain();

        // heavier idling and frequent held ticks under both settings
        write_overscan(1'b0);
        run_beats(RANDOM_BEATS, 6, 4);
        drain();
        write_overscan(1'b1);
        run_beats(RANDOM_BEATS, 6, 4);
        drain();

        // catch any stray result beat after the last one due
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
